>>> rtl/mf3_pkg.sv
// Shared types, constants and the nine-input median network for the 3x3 median filter.
package mf3_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROWS_W    = 13;
  localparam int unsigned COLS_W    = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned ROT_W     = 2;
  localparam int unsigned N_CX      = 19;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROT_W-1:0] rot_t;
  typedef pix_t             win_t [9];

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

  // Line rotation values
  localparam rot_t ROT_0    = 2'd0;
  localparam rot_t ROT_1    = 2'd1;
  localparam rot_t ROT_2    = 2'd2;
  localparam rot_t ROT_INIT = ROT_2;

  // Compare-exchange pairs of the 19-step median-of-nine network.
  // Each step leaves the smaller value at CX_LO and the larger at CX_HI.
  localparam int unsigned CX_LO [N_CX] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0,
                                           5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int unsigned CX_HI [N_CX] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3,
                                           8, 7, 6, 4, 5, 7, 2, 4, 2};

  // Median of nine pixels through the fixed exchange network
  function automatic pix_t median9(input win_t w);
    win_t p;
    pix_t a;
    pix_t b;
    p = w;
    for (int unsigned k = 0; k < N_CX; k++) begin
      a = p[CX_LO[k]];
      b = p[CX_HI[k]];
      if (a > b) begin
        p[CX_LO[k]] = b;
        p[CX_HI[k]] = a;
      end
    end
    return p[4];
  endfunction

endpackage

>>> rtl/median_filter_3x3_stream.sv
// 3x3 median filter over a pixel stream with three rotating line memories.
// Pipeline: a pixel transfer fills stage 1 with the line memory reads, then its result fills the output register.
// Throughput: one pixel per cycle unless m_axis_tready stalls the output; the line memories are read and written in the
//   transfer cycle, the median network sits between the read register and the output.
// The first row of a frame primes the line memories and gives no results.
// Reset (rst_ni low, asynchronous) empties the pipe, restores the registers to
//   720 rows and 1280 columns and restarts the frame; line memory is not cleared.
module median_filter_3x3_stream #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mf3_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  // Pixel input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] pixel_in
  // Median output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // [7:0] median_out
  output logic                             m_axis_tlast    // frame_end
);
  import mf3_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

  // Configuration registers
  logic [ROWS_W-1:0] frame_rows_q;
  logic [COLS_W-1:0] frame_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= ROWS_W'(720);
      frame_cols_q <= COLS_W'(1280);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_ROWS: frame_rows_q <= cfg_data_i[ROWS_W-1:0];
        REG_FRAME_COLS: frame_cols_q <= cfg_data_i[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, columns saturate at the line width
  logic [ROWS_W-1:0] rows_eff;
  logic [CNT_W-1:0]  cols_eff;

  always_comb begin
    rows_eff = (frame_rows_q == '0) ? ROWS_W'(1) : frame_rows_q;
    if (frame_cols_q == '0) begin
      cols_eff = CNT_W'(1);
    end else if (CNT_W'(frame_cols_q) > CNT_W'(MAX_WIDTH)) begin
      cols_eff = CNT_W'(MAX_WIDTH);
    end else begin
      cols_eff = CNT_W'(frame_cols_q);
    end
  end

  // Handshake and pipe control
  logic s1_v_q;
  logic out_v_q;
  logic out_adv;
  logic s1_adv;
  logic in_xfer;

  assign out_adv       = !out_v_q || m_axis_tready;
  assign s1_adv        = s1_v_q && out_adv;
  assign s_axis_tready = !s1_v_q || out_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Raster position
  logic [CW-1:0]     col_q;
  logic [ROWS_W-1:0] row_q;
  rot_t              rot_q;
  logic              row_done;
  logic              priming;
  logic              flush;
  logic [CNT_W-1:0]  col_next;

  assign col_next = CNT_W'(col_q) + CNT_W'(1);
  assign row_done = col_next >= cols_eff;
  assign priming  = (row_q == '0);
  assign flush    = (row_q >= rows_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rot_q <= ROT_INIT;
    end else if (in_xfer) begin
      if (!row_done) begin
        col_q <= col_next[CW-1:0];
      end else begin
        col_q <= '0;
        if (priming) begin
          row_q <= ROWS_W'(1);
        end else if (flush) begin
          row_q <= '0;
          rot_q <= ROT_INIT;
        end else begin
          row_q <= row_q + ROWS_W'(1);
          rot_q <= (rot_q == ROT_2) ? ROT_0 : rot_q + ROT_1;
        end
      end
    end
  end

  // Line roles: bottom is written now, top and middle are read
  rot_t top_sel;
  rot_t mid_sel;
  pix_t px_in;
  pix_t btm_pix;

  assign px_in   = s_axis_tdata;
  assign top_sel = (rot_q == ROT_2) ? ROT_0 : rot_q + ROT_1;
  assign mid_sel = (rot_q == ROT_0) ? ROT_2 : rot_q - ROT_1;
  assign btm_pix = flush ? '0 : px_in;

  // Line memory write selects; the priming row writes zeros to line 0 and pixels to line 1
  logic [2:0] line_we;
  pix_t       line_wd [3];
  pix_t       line_rd [3];

  always_comb begin
    for (int unsigned l = 0; l < 3; l++) begin
      line_we[l] = 1'b0;
      line_wd[l] = btm_pix;
    end
    if (priming) begin
      line_we[0] = in_xfer;
      line_wd[0] = '0;
      line_we[1] = in_xfer;
      line_wd[1] = px_in;
    end else begin
      line_we[rot_q] = in_xfer;
    end
  end

  // Three line memories, one write and one registered read each
  for (genvar g = 0; g < 3; g++) begin : g_line
    pix_t mem [MAX_WIDTH];
    pix_t rd_q;

    always_ff @(posedge clk_i) begin
      if (line_we[g]) begin
        mem[col_q] <= line_wd[g];
      end
      if (in_xfer) begin
        rd_q <= mem[col_q];
      end
    end

    assign line_rd[g] = rd_q;
  end

  // Stage 1: side data that travels with the memory read
  logic s1_first_q;
  logic s1_last_q;
  pix_t s1_btm_q;
  rot_t s1_top_q;
  rot_t s1_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_xfer) begin
      s1_v_q <= !priming;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_first_q <= (col_q == '0);
      s1_last_q  <= flush && row_done;
      s1_btm_q   <= btm_pix;
      s1_top_q   <= top_sel;
      s1_mid_q   <= mid_sel;
    end
  end

  // Current column of the window, top to bottom
  pix_t cur [3];

  assign cur[0] = line_rd[s1_top_q];
  assign cur[1] = line_rd[s1_mid_q];
  assign cur[2] = s1_btm_q;

  // Two previous columns per window row; a new row starts from zero padding
  pix_t hist0_q [3];
  pix_t hist1_q [3];
  win_t win;

  always_comb begin
    for (int unsigned r = 0; r < 3; r++) begin
      win[r*3]     = s1_first_q ? '0 : hist0_q[r];
      win[r*3 + 1] = s1_first_q ? '0 : hist1_q[r];
      win[r*3 + 2] = cur[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int unsigned r = 0; r < 3; r++) begin
        hist0_q[r] <= win[r*3 + 1];
        hist1_q[r] <= cur[r];
      end
    end
  end

  // Output register
  pix_t out_med_q;
  logic out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_med_q  <= median9(win);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_med_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q != 2'd3)
    else $error("line rotation out of range");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(col_q) < CNT_W'(MAX_WIDTH))
    else $error("column index beyond line width");

  a_prime_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && priming) |=> !s1_v_q)
    else $error("priming row produced a result");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_v_q))
    else $error("result without a stage-1 entry");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> s_axis_tready)
    else $error("input stalled with an empty stage 1");

endmodule
